// ===== rtl/core/crw_pkg.sv =====
// Package for the CSR random walk step block: field widths, table depths,
// action and status codes. No dependencies.
package crw_pkg;
  localparam int NODES = 1024;
  localparam int EDGES = 8192;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_W = 10;
  localparam int IDX_W = 13;
  localparam int OFS_W = 14;
  localparam int TGT_W = 10;
  localparam int WIN_W = 16;
  localparam int RND_W = 32;
  localparam int NA_W = $clog2(NODES + 1);
  localparam int EA_W = $clog2(EDGES);
  localparam int TOT_W = WEIGHT_BITS + EA_W + 1;

  localparam logic [1:0] ACT_LOAD_OFS = 2'd0;
  localparam logic [1:0] ACT_LOAD_EDGE = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_STEP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_EDGES = 2'd1;
  localparam logic [1:0] ST_ZERO_WEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [IDX_W-1:0] table_index;
    logic [OFS_W-1:0] edge_offset;
    logic [TGT_W-1:0] edge_target;
    logic [WIN_W-1:0] edge_weight;
    logic [NODE_W-1:0] start_node;
    logic [RND_W-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [1:0] status;
  } out_item_t;

  // Divider control between the sequencer and the bit-serial divider.
  typedef struct packed {
    logic start;
    logic [RND_W-1:0] dividend;
    logic [TOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [TOT_W-1:0] rem;
  } div_rsp_t;
endpackage

// ===== rtl/core/crw_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on crw_pkg.
interface crw_in_if (input logic clk);
  logic valid;
  logic ready;
  crw_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crw_out_if (input logic clk);
  logic valid;
  logic ready;
  crw_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/csr_graph_random_walk_step.sv =====
// Top level of the CSR random walk step block: tables, step sequencer and
// result register. Depends on crw_pkg, crw_if and crw_div.
//
// A load writes its table and returns no result; a start returns the start
// node with status OK. A uniform step draws its edge with the bit-serial
// remainder unit. A weighted step for a node of degree D makes one table read
// per edge to sum the weights, the remainder pass, then a scan of one read per
// edge, which stops at the chosen edge. The tables have one write port and one
// registered read port each and are not cleared; an entry read before it is
// written returns anything.
// The next item is taken once the result has left the output register.
module csr_graph_random_walk_step (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic cfg_wdata,
  crw_in_if.sink in_ch,
  crw_out_if.source out_ch
);
  import crw_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_OFS0 = 4'd1, S_OFS1 = 4'd2,
    S_OFS2 = 4'd3, S_SUM = 4'd4, S_DIV = 4'd5, S_SCAN = 4'd6,
    S_PICK = 4'd7, S_PICK2 = 4'd8, S_DONE = 4'd9;

  logic [OFS_W-1:0] offset_mem [NODES+1];
  logic [TGT_W-1:0] target_mem [EDGES];
  logic [WEIGHT_BITS-1:0] weight_mem [EDGES];

  logic walk_mode;
  logic [3:0] state;
  logic [NODE_W-1:0] current_node;
  in_item_t item;
  logic [OFS_W-1:0] ofs_q, first, last;
  logic [NA_W-1:0] ofs_addr;
  logic [EA_W:0] e;
  logic [TGT_W-1:0] tgt_q;
  logic [WEIGHT_BITS-1:0] wgt_q;
  logic [TOT_W-1:0] total, run, rthr;
  logic rd_pending;
  logic [1:0] status;
  div_req_t dreq;
  div_rsp_t drsp;

  crw_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  always_ff @(posedge clk) begin
    if (rst) walk_mode <= 1'b0;
    else if (cfg_we) walk_mode <= cfg_wdata;
  end

  // Table writes happen straight from the accepted item.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.data.action == ACT_LOAD_OFS && 32'(in_ch.data.table_index) <= NODES)
        offset_mem[in_ch.data.table_index[NA_W-1:0]] <= in_ch.data.edge_offset;
      if (in_ch.data.action == ACT_LOAD_EDGE && 32'(in_ch.data.table_index) < EDGES) begin
        target_mem[in_ch.data.table_index[EA_W-1:0]] <= in_ch.data.edge_target[TGT_W-1:0];
        weight_mem[in_ch.data.table_index[EA_W-1:0]] <=
          in_ch.data.edge_weight[WEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ofs_q <= offset_mem[ofs_addr];
    tgt_q <= target_mem[e[EA_W-1:0]];
    wgt_q <= weight_mem[e[EA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      current_node <= '0;
      out_ch.valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            if (in_ch.data.action == ACT_START) begin
              current_node <= in_ch.data.start_node[NODE_W-1:0];
              out_ch.data.node <= in_ch.data.start_node[NODE_W-1:0];
              out_ch.data.status <= ST_OK;
              out_ch.valid <= 1'b1;
            end else if (in_ch.data.action == ACT_STEP) begin
              ofs_addr <= NA_W'(current_node);
              state <= S_OFS0;
            end
          end
        end
        S_OFS0: begin
          ofs_addr <= NA_W'(current_node) + 1'b1;
          state <= S_OFS1;
        end
        S_OFS1: begin
          first <= ofs_q;
          state <= S_OFS2;
        end
        S_OFS2: begin
          // Node ids below NODES always hold here at the default size.
          last <= (32'(ofs_q) > EDGES) ? OFS_W'(EDGES) : ofs_q;
          if (first >= ((32'(ofs_q) > EDGES) ? OFS_W'(EDGES) : ofs_q) ||
              32'(current_node) >= NODES) begin
            status <= ST_NO_EDGES;
            state <= S_DONE;
          end else if (!walk_mode) begin
            dreq.start <= 1'b1;
            dreq.dividend <= item.random_word;
            dreq.divisor <= TOT_W'(((32'(ofs_q) > EDGES) ? OFS_W'(EDGES) : ofs_q) - first);
            status <= ST_OK;
            state <= S_DIV;
          end else begin
            e <= (EA_W+1)'(first);
            total <= '0;
            rd_pending <= 1'b0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // One read issued per cycle, accumulated in the cycle after.
          if (rd_pending) total <= total + TOT_W'(wgt_q);
          if (32'(e) < 32'(last)) begin
            e <= e + 1'b1;
            rd_pending <= 1'b1;
          end else if (rd_pending) begin
            rd_pending <= 1'b0;
          end else begin
            if (total == '0) begin
              status <= ST_ZERO_WEIGHT;
              state <= S_DONE;
            end else begin
              dreq.start <= 1'b1;
              dreq.dividend <= item.random_word;
              dreq.divisor <= total;
              status <= ST_OK;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (!walk_mode) begin
              e <= (EA_W+1)'(first) + (EA_W+1)'(drsp.rem);
              state <= S_PICK;
            end else begin
              rthr <= drsp.rem + 1'b1;
              run <= '0;
              e <= (EA_W+1)'(first);
              state <= S_SCAN;
              rd_pending <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // Address e is held while its registered read completes, then its weight is added.
          if (!rd_pending) rd_pending <= 1'b1;
          else begin
            rd_pending <= 1'b0;
            if (run + TOT_W'(wgt_q) >= rthr || 32'(e) + 1 >= 32'(last)) state <= S_PICK;
            else begin
              run <= run + TOT_W'(wgt_q);
              e <= e + 1'b1;
            end
          end
        end
        S_PICK: state <= S_PICK2;
        S_PICK2: begin
          current_node <= tgt_q;
          state <= S_DONE;
        end
        S_DONE: begin
          out_ch.data.node <= current_node;
          out_ch.data.status <= status;
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/crw_div.sv =====
// Restoring bit-serial remainder unit, one quotient bit per cycle.
// Depends on crw_pkg.
module crw_div (
  input logic clk,
  input logic rst,
  input crw_pkg::div_req_t req,
  output crw_pkg::div_rsp_t rsp
);
  import crw_pkg::*;
  localparam int CNT_W = $clog2(RND_W + 1);
  logic [RND_W-1:0] dividend;
  logic [TOT_W-1:0] divisor;
  logic [TOT_W:0] rem;
  logic [CNT_W-1:0] count;
  logic busy;
  logic [TOT_W:0] shifted;

  assign shifted = {rem[TOT_W-1:0], dividend[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= CNT_W'(RND_W);
        dividend <= req.dividend;
        divisor <= req.divisor;
        rem <= '0;
      end else if (busy) begin
        dividend <= {dividend[RND_W-2:0], 1'b0};
        if (shifted >= {1'b0, divisor}) rem <= shifted - {1'b0, divisor};
        else rem <= shifted;
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end
  assign rsp.rem = rem[TOT_W-1:0];
endmodule
